// ===== rtl/scpd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scpd_pkg
// Shared types, constants and the sine lookup for the phase duty core.
// ----------------------------------------------------------------------------
package scpd_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 120;
    localparam int POS_W         = $clog2(TABLE_ENTRIES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(TABLE_ENTRIES - 1);

    // fixed point formats
    localparam int AMP_W         = 12;
    localparam int AMP_FRAC_BITS = 10;
    localparam int TAB_FRAC_BITS = 16;
    localparam int SUM_FRAC_BITS = AMP_FRAC_BITS + TAB_FRAC_BITS;
    localparam int SAMPLE_W      = 17;
    localparam int SUM_W         = AMP_W + 1 + SAMPLE_W;
    localparam int DUTY_W        = 16;
    localparam int DUTY_BITS_DEF = 16;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = AMP_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_PHASE_OFFSET = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_AMPLITUDE    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DRIVE_ENABLE = 2'd2;

    localparam logic [AMP_W-1:0] AMP_RESET = 12'd512;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // command into the position / rom stage
    typedef struct packed {
        logic             step;
        logic             dir;
        logic             load;
        logic [POS_W-1:0] offset;
    } t_pos_cmd;

    // beat held in the rom stage
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] pos;
        t_sample          entry;
    } t_s1_beat;

    // half-amplitude sine samples, signed q0.16
    localparam t_sample SINE_Q16 [TABLE_ENTRIES] = '{
        17'sd0, 17'sd1729, 17'sd3454, 17'sd5169, 17'sd6869, 17'sd8550, 17'sd10208,
        17'sd11837, 17'sd13433, 17'sd14992, 17'sd16509, 17'sd17980, 17'sd19400,
        17'sd20767, 17'sd22076, 17'sd23323, 17'sd24505, 17'sd25619, 17'sd26661,
        17'sd27630, 17'sd28521, 17'sd29333, 17'sd30063, 17'sd30709, 17'sd31269,
        17'sd31743, 17'sd32128, 17'sd32423, 17'sd32628, 17'sd32742, 17'sd32765,
        17'sd32697, 17'sd32537, 17'sd32287, 17'sd31946, 17'sd31517, 17'sd31000,
        17'sd30396, 17'sd29708, 17'sd28937, 17'sd28085, 17'sd27155, 17'sd26150,
        17'sd25071, 17'sd23923, 17'sd22707, 17'sd21429, 17'sd20091, 17'sd18696,
        17'sd17250, 17'sd15756, 17'sd14217, 17'sd12640, 17'sd11026, 17'sd9383,
        17'sd7713, 17'sd6021, 17'sd4313, 17'sd2593, 17'sd865,
        -17'sd865, -17'sd2593, -17'sd4313, -17'sd6021, -17'sd7713, -17'sd9383,
        -17'sd11026, -17'sd12640, -17'sd14217, -17'sd15756, -17'sd17250,
        -17'sd18696, -17'sd20091, -17'sd21429, -17'sd22707, -17'sd23923,
        -17'sd25071, -17'sd26150, -17'sd27155, -17'sd28085, -17'sd28937,
        -17'sd29708, -17'sd30396, -17'sd31000, -17'sd31517, -17'sd31946,
        -17'sd32287, -17'sd32537, -17'sd32697, -17'sd32765, -17'sd32742,
        -17'sd32628, -17'sd32423, -17'sd32128, -17'sd31743, -17'sd31269,
        -17'sd30709, -17'sd30063, -17'sd29333, -17'sd28521, -17'sd27630,
        -17'sd26661, -17'sd25619, -17'sd24505, -17'sd23323, -17'sd22076,
        -17'sd20767, -17'sd19400, -17'sd17980, -17'sd16509, -17'sd14992,
        -17'sd13433, -17'sd11837, -17'sd10208, -17'sd8550, -17'sd6869,
        -17'sd5169, -17'sd3454, -17'sd1729, 17'sd0
    };

    // offsets past the table end load the last entry
    function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p);
        clamp_pos = (p > POS_LAST) ? POS_LAST : p;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/scpd_pos_rom.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scpd_pos_rom
// Position register with wrap in both directions, and the synchronous sine
// rom read at the stepped position.
// ----------------------------------------------------------------------------
module scpd_pos_rom (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire scpd_pkg::t_pos_cmd i_cmd,
    input  wire logic              i_adv,
    output scpd_pkg::t_s1_beat     o_s1
);

    logic [scpd_pkg::POS_W-1:0] r_pos;
    logic [scpd_pkg::POS_W-1:0] n_pos;
    logic [scpd_pkg::POS_W-1:0] r_s1_pos;
    logic                       r_s1_valid;
    scpd_pkg::t_sample          r_entry;

    // next position, wrapping at both ends
    always_comb begin
        if (i_cmd.dir == 1'b0) begin
            n_pos = (r_pos == scpd_pkg::POS_LAST) ? '0 : r_pos + 1'b1;
        end else begin
            n_pos = (r_pos == '0) ? scpd_pkg::POS_LAST : r_pos - 1'b1;
        end
    end

    // position register; an offset write reloads it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_cmd.load) begin
            r_pos <= scpd_pkg::clamp_pos(i_cmd.offset);
        end else if (i_cmd.step) begin
            r_pos <= n_pos;
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_s1_valid <= 1'b1;
        end else if (i_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // rom read, registered data
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_entry  <= scpd_pkg::SINE_Q16[n_pos];
            r_s1_pos <= n_pos;
        end
    end

    assign o_s1.valid = r_s1_valid;
    assign o_s1.pos   = r_s1_pos;
    assign o_s1.entry = r_entry;

endmodule
`default_nettype wire

// ===== rtl/sine_commutation_phase_duty_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sine_commutation_phase_duty_core
// PWM duty for one motor phase: each step moves through a sine table and
// the duty is one half plus amplitude times the sample, saturated.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_direction
//  out      output     o_out_valid / i_out_stall o_duty o_position o_inhibit_n
//                                                o_clipped
//  cfg      input      i_cfg_we                  i_cfg_addr i_cfg_wdata
//
//  an accepted beat passes the rom read register, then multiply, round and
//  saturate into the output register. one beat per cycle sustained unless
//  out stalls; the output register and the rom stage each hold one beat, so
//  the input stalls only while both are full and out stalls.
//  synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module sine_commutation_phase_duty_core #(
    parameter int DUTY_BITS = scpd_pkg::DUTY_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_direction,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [scpd_pkg::DUTY_W-1:0]          o_duty,
    output logic [scpd_pkg::POS_W-1:0]           o_position,
    output logic                                 o_inhibit_n,
    output logic                                 o_clipped,
    input  wire logic                            i_cfg_we,
    input  wire logic [scpd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [scpd_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int SHIFT = scpd_pkg::SUM_FRAC_BITS - DUTY_BITS;
    localparam int SW    = scpd_pkg::SUM_W;
    localparam logic signed [SW-1:0] C_HALF  = SW'(1) << (scpd_pkg::SUM_FRAC_BITS - 1);
    localparam logic signed [SW-1:0] C_ROUND = SW'(1) << (SHIFT - 1);

    logic [scpd_pkg::AMP_W-1:0] r_amplitude;
    logic                       r_drive_enable;
    logic                       r_out_valid;
    logic [DUTY_BITS-1:0]       r_duty;
    logic [scpd_pkg::POS_W-1:0] r_position;
    logic                       r_inhibit_n;
    logic                       r_clipped;

    logic                       w_adv;
    scpd_pkg::t_pos_cmd         w_cmd;
    scpd_pkg::t_s1_beat         w_s1;
    logic signed [SW-1:0]       w_prod;
    logic signed [SW-1:0]       w_sum;
    logic                       w_neg;
    logic                       w_over;
    logic [DUTY_BITS-1:0]       w_duty;

    // handshake: output register frees, rom stage moves up
    assign w_adv       = !r_out_valid || !i_out_stall;
    assign o_in_stall  = w_s1.valid && !w_adv;

    // command to the position stage
    always_comb begin
        w_cmd.step   = i_in_valid && !o_in_stall;
        w_cmd.dir    = i_direction;
        w_cmd.load   = i_cfg_we && (i_cfg_addr == scpd_pkg::CFG_PHASE_OFFSET);
        w_cmd.offset = i_cfg_wdata[scpd_pkg::POS_W-1:0];
    end

    scpd_pos_rom u_pos_rom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_adv   (w_adv),
        .o_s1    (w_s1)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude    <= scpd_pkg::AMP_RESET;
            r_drive_enable <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == scpd_pkg::CFG_AMPLITUDE) begin
                r_amplitude <= i_cfg_wdata;
            end
            if (i_cfg_addr == scpd_pkg::CFG_DRIVE_ENABLE) begin
                r_drive_enable <= i_cfg_wdata[0];
            end
        end
    end

    // half plus scaled sample, rounded half up, then saturated
    always_comb begin
        w_prod = SW'($signed({1'b0, r_amplitude})) * SW'($signed(w_s1.entry));
        w_sum  = w_prod + C_HALF + C_ROUND;
        w_neg  = w_sum[SW-1];
        w_over = |w_sum[SW-2:scpd_pkg::SUM_FRAC_BITS];
        priority if (w_neg) begin
            w_duty = '0;
        end else if (w_over) begin
            w_duty = '1;
        end else begin
            w_duty = w_sum[scpd_pkg::SUM_FRAC_BITS-1:SHIFT];
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_s1.valid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_adv && w_s1.valid) begin
            r_duty      <= w_duty;
            r_position  <= w_s1.pos;
            r_inhibit_n <= r_drive_enable;
            r_clipped   <= w_neg || w_over;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_duty      = scpd_pkg::DUTY_W'(r_duty);
    assign o_position  = r_position;
    assign o_inhibit_n = r_inhibit_n;
    assign o_clipped   = r_clipped;

endmodule
`default_nettype wire
